// ----- src/stto_pkg.sv -----
// ----------------------------------------------------------------------------
// Sphere/triangle overlap test package
// Shared widths, types and small arithmetic helpers for the overlap pipeline.
// ----------------------------------------------------------------------------
package stto_pkg;

   localparam int COORD_FRAC_BITS_DEFAULT = 16;
   localparam int COORD_W  = 32;
   localparam int RADIUS_W = 27;
   localparam logic [RADIUS_W-1:0] RADIUS_RESET = 27'd327680;
   localparam int RSQ_W    = 2 * RADIUS_W;

   // Exact widths of the intermediate quantities.
   localparam int DIFF_W = COORD_W + 1;       // vertex or centre difference
   localparam int PROD_W = 2 * DIFF_W;        // product of two differences
   localparam int DOT_W  = PROD_W + 2;        // sum of three such products
   localparam int NRM_W  = PROD_W + 1;        // cross product component
   localparam int AREA_W = 2 * DOT_W + 1;     // Gram determinant and numerators

   // The degenerate threshold is 1e-8 in real units.
   localparam int DEGEN_SCALE = 100000000;

   typedef struct packed {
      logic signed [DOT_W-1:0] bb;      // |b-a|^2
      logic signed [DOT_W-1:0] bc;      // (b-a).(c-a)
      logic signed [DOT_W-1:0] cc;      // |c-a|^2
      logic signed [DOT_W-1:0] pb;      // (p-a).(b-a)
      logic signed [DOT_W-1:0] pc;      // (p-a).(c-a)
      logic signed [DOT_W-1:0] rr_a;    // |p-a|^2
      logic signed [DOT_W-1:0] rr_b;    // |p-b|^2
      logic signed [DOT_W-1:0] rr_c;    // |p-c|^2
      logic signed [DOT_W-1:0] len_bc;  // |c-b|^2
      logic signed [DOT_W-1:0] al_bc;   // (p-b).(c-b)
      logic signed [DOT_W-1:0] al_ca;   // (p-c).(a-c)
      logic [2:0][NRM_W-1:0]   nrm;     // (b-a) x (c-a)
      logic [2:0][DIFF_W-1:0]  rp;      // p-a
   } stto_geom_type;

   typedef struct packed {
      logic [2:0] start_behind;  // projection falls before the edge start
      logic [2:0] end_beyond;    // projection falls past the edge end
      logic [2:0] start_near;    // edge start lies within the radius
      logic [2:0] end_near;      // edge end lies within the radius
      logic       vtx_a_near;    // vertex a lies within the radius
   } stto_flags_type;

   function automatic logic signed [PROD_W-1:0] smul(input logic signed [DIFF_W-1:0] x,
                                                     input logic signed [DIFF_W-1:0] y);
      logic signed [PROD_W-1:0] xx;
      logic signed [PROD_W-1:0] yy;
      xx = PROD_W'(x);
      yy = PROD_W'(y);
      return xx * yy;
   endfunction

   function automatic logic signed [DOT_W-1:0] dot3(input logic signed [PROD_W-1:0] p0,
                                                    input logic signed [PROD_W-1:0] p1,
                                                    input logic signed [PROD_W-1:0] p2);
      return DOT_W'(p0) + DOT_W'(p1) + DOT_W'(p2);
   endfunction

endpackage

// ----- src/stto_req_if.sv -----
// ----------------------------------------------------------------------------
// Query channel
// Valid/ready channel that carries one sphere centre and one triangle.
// ----------------------------------------------------------------------------
interface stto_req_if;
   import stto_pkg::*;

   logic valid;
   logic ready;
   logic signed [COORD_W-1:0] center_x;
   logic signed [COORD_W-1:0] center_y;
   logic signed [COORD_W-1:0] center_z;
   logic signed [COORD_W-1:0] vertex_a_x;
   logic signed [COORD_W-1:0] vertex_a_y;
   logic signed [COORD_W-1:0] vertex_a_z;
   logic signed [COORD_W-1:0] vertex_b_x;
   logic signed [COORD_W-1:0] vertex_b_y;
   logic signed [COORD_W-1:0] vertex_b_z;
   logic signed [COORD_W-1:0] vertex_c_x;
   logic signed [COORD_W-1:0] vertex_c_y;
   logic signed [COORD_W-1:0] vertex_c_z;

   modport source (
      output valid, center_x, center_y, center_z,
             vertex_a_x, vertex_a_y, vertex_a_z,
             vertex_b_x, vertex_b_y, vertex_b_z,
             vertex_c_x, vertex_c_y, vertex_c_z,
      input  ready
   );

   modport sink (
      input  valid, center_x, center_y, center_z,
             vertex_a_x, vertex_a_y, vertex_a_z,
             vertex_b_x, vertex_b_y, vertex_b_z,
             vertex_c_x, vertex_c_y, vertex_c_z,
      output ready
   );
endinterface

// ----- src/stto_rsp_if.sv -----
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries the one-bit overlap answer.
// ----------------------------------------------------------------------------
interface stto_rsp_if;
   logic valid;
   logic ready;
   logic hit;

   modport source (output valid, hit, input ready);
   modport sink (input valid, hit, output ready);
endinterface

// ----- src/stto_mul.sv -----
// ----------------------------------------------------------------------------
// Pipelined signed multiplier
// Splits both operands into 32-bit digits, registers the digit by digit
// partial products, then registers their shifted sum.
// ----------------------------------------------------------------------------
module stto_mul #(
   parameter int AW = 68,
   parameter int BW = 68
) (
   input  logic                    clock,
   input  logic                    advance,
   input  logic signed [AW-1:0]    a,
   input  logic signed [BW-1:0]    b,
   output logic signed [AW+BW-1:0] p
);
   localparam int CW = 32;
   localparam int NA = (AW + CW - 1) / CW;
   localparam int NB = (BW + CW - 1) / CW;
   localparam int XA = NA * CW;
   localparam int XB = NB * CW;
   localparam int DW = CW + 1;
   localparam int PW = 2 * DW;
   localparam int SW = XA + XB;

   logic signed [XA-1:0]    a_ext;
   logic signed [XB-1:0]    b_ext;
   logic signed [DW-1:0]    a_dig [NA];
   logic signed [DW-1:0]    b_dig [NB];
   logic signed [PW-1:0]    pp_in [NA][NB];
   logic signed [PW-1:0]    pp_ff [NA][NB];
   logic signed [SW-1:0]    sum_in;
   logic signed [AW+BW-1:0] p_ff;

   assign a_ext = XA'(a);
   assign b_ext = XB'(b);

   // The top digit of each operand carries the sign; the lower digits are
   // unsigned.
   always_comb begin
      for (int i = 0; i < NA; i++) begin
         if (i == NA - 1) begin
            a_dig[i] = DW'($signed(a_ext[i*CW +: CW]));
         end else begin
            a_dig[i] = $signed({1'b0, a_ext[i*CW +: CW]});
         end
      end
      for (int j = 0; j < NB; j++) begin
         if (j == NB - 1) begin
            b_dig[j] = DW'($signed(b_ext[j*CW +: CW]));
         end else begin
            b_dig[j] = $signed({1'b0, b_ext[j*CW +: CW]});
         end
      end
      for (int i = 0; i < NA; i++) begin
         for (int j = 0; j < NB; j++) begin
            pp_in[i][j] = a_dig[i] * b_dig[j];
         end
      end
   end

   always_comb begin
      sum_in = '0;
      for (int i = 0; i < NA; i++) begin
         for (int j = 0; j < NB; j++) begin
            sum_in = sum_in + (SW'(pp_ff[i][j]) <<< ((i + j) * CW));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < NA; i++) begin
            for (int j = 0; j < NB; j++) begin
               pp_ff[i][j] <= pp_in[i][j];
            end
         end
         p_ff <= sum_in[AW+BW-1:0];
      end
   end

   assign p = p_ff;
endmodule

// ----- src/stto_geom.sv -----
// ----------------------------------------------------------------------------
// Geometry front end
// Three register stages: coordinate differences, their pairwise products,
// and the dot and cross products built from them.
// ----------------------------------------------------------------------------
module stto_geom (
   input  logic                                clock,
   input  logic                                advance,
   input  logic signed [stto_pkg::COORD_W-1:0] cen [3],
   input  logic signed [stto_pkg::COORD_W-1:0] va  [3],
   input  logic signed [stto_pkg::COORD_W-1:0] vb  [3],
   input  logic signed [stto_pkg::COORD_W-1:0] vc  [3],
   output stto_pkg::stto_geom_type             geom
);
   import stto_pkg::*;

   logic signed [DIFF_W-1:0] eb_ff [3];
   logic signed [DIFF_W-1:0] ec_ff [3];
   logic signed [DIFF_W-1:0] rp_ff [3];
   logic signed [DIFF_W-1:0] dbc_ff [3];
   logic signed [DIFF_W-1:0] rb_ff [3];
   logic signed [DIFF_W-1:0] rc_ff [3];
   logic signed [DIFF_W-1:0] rp_d2_ff [3];

   logic signed [PROD_W-1:0] bb_p_ff [3];
   logic signed [PROD_W-1:0] bc_p_ff [3];
   logic signed [PROD_W-1:0] cc_p_ff [3];
   logic signed [PROD_W-1:0] pb_p_ff [3];
   logic signed [PROD_W-1:0] pc_p_ff [3];
   logic signed [PROD_W-1:0] ra_p_ff [3];
   logic signed [PROD_W-1:0] lbc_p_ff [3];
   logic signed [PROD_W-1:0] abc_p_ff [3];
   logic signed [PROD_W-1:0] rbb_p_ff [3];
   logic signed [PROD_W-1:0] aca_p_ff [3];
   logic signed [PROD_W-1:0] rcc_p_ff [3];
   logic signed [PROD_W-1:0] nl_p_ff [3];
   logic signed [PROD_W-1:0] nr_p_ff [3];

   stto_geom_type geom_in;
   stto_geom_type geom_ff;

   // Stage 1: differences.
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 3; i++) begin
            eb_ff[i]  <= DIFF_W'(vb[i]) - DIFF_W'(va[i]);
            ec_ff[i]  <= DIFF_W'(vc[i]) - DIFF_W'(va[i]);
            rp_ff[i]  <= DIFF_W'(cen[i]) - DIFF_W'(va[i]);
            dbc_ff[i] <= DIFF_W'(vc[i]) - DIFF_W'(vb[i]);
            rb_ff[i]  <= DIFF_W'(cen[i]) - DIFF_W'(vb[i]);
            rc_ff[i]  <= DIFF_W'(cen[i]) - DIFF_W'(vc[i]);
         end
      end
   end

   // Stage 2: products of differences.
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 3; i++) begin
            bb_p_ff[i]  <= smul(eb_ff[i], eb_ff[i]);
            bc_p_ff[i]  <= smul(eb_ff[i], ec_ff[i]);
            cc_p_ff[i]  <= smul(ec_ff[i], ec_ff[i]);
            pb_p_ff[i]  <= smul(rp_ff[i], eb_ff[i]);
            pc_p_ff[i]  <= smul(rp_ff[i], ec_ff[i]);
            ra_p_ff[i]  <= smul(rp_ff[i], rp_ff[i]);
            lbc_p_ff[i] <= smul(dbc_ff[i], dbc_ff[i]);
            abc_p_ff[i] <= smul(rb_ff[i], dbc_ff[i]);
            rbb_p_ff[i] <= smul(rb_ff[i], rb_ff[i]);
            aca_p_ff[i] <= smul(rc_ff[i], ec_ff[i]);
            rcc_p_ff[i] <= smul(rc_ff[i], rc_ff[i]);
            rp_d2_ff[i] <= rp_ff[i];
         end
         nl_p_ff[0] <= smul(eb_ff[1], ec_ff[2]);
         nr_p_ff[0] <= smul(eb_ff[2], ec_ff[1]);
         nl_p_ff[1] <= smul(eb_ff[2], ec_ff[0]);
         nr_p_ff[1] <= smul(eb_ff[0], ec_ff[2]);
         nl_p_ff[2] <= smul(eb_ff[0], ec_ff[1]);
         nr_p_ff[2] <= smul(eb_ff[1], ec_ff[0]);
      end
   end

   // Stage 3: sums. The edge from c to a runs along -(c-a).
   always_comb begin
      geom_in.bb     = dot3(bb_p_ff[0], bb_p_ff[1], bb_p_ff[2]);
      geom_in.bc     = dot3(bc_p_ff[0], bc_p_ff[1], bc_p_ff[2]);
      geom_in.cc     = dot3(cc_p_ff[0], cc_p_ff[1], cc_p_ff[2]);
      geom_in.pb     = dot3(pb_p_ff[0], pb_p_ff[1], pb_p_ff[2]);
      geom_in.pc     = dot3(pc_p_ff[0], pc_p_ff[1], pc_p_ff[2]);
      geom_in.rr_a   = dot3(ra_p_ff[0], ra_p_ff[1], ra_p_ff[2]);
      geom_in.rr_b   = dot3(rbb_p_ff[0], rbb_p_ff[1], rbb_p_ff[2]);
      geom_in.rr_c   = dot3(rcc_p_ff[0], rcc_p_ff[1], rcc_p_ff[2]);
      geom_in.len_bc = dot3(lbc_p_ff[0], lbc_p_ff[1], lbc_p_ff[2]);
      geom_in.al_bc  = dot3(abc_p_ff[0], abc_p_ff[1], abc_p_ff[2]);
      geom_in.al_ca  = -dot3(aca_p_ff[0], aca_p_ff[1], aca_p_ff[2]);
      for (int i = 0; i < 3; i++) begin
         geom_in.nrm[i] = NRM_W'(nl_p_ff[i]) - NRM_W'(nr_p_ff[i]);
         geom_in.rp[i]  = rp_d2_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         geom_ff <= geom_in;
      end
   end

   assign geom = geom_ff;
endmodule

// ----- src/sphere_triangle_overlap_test.sv -----
// ----------------------------------------------------------------------------
// Sphere/triangle overlap test
// Decides whether a sphere of programmable radius touches a triangle, with
// exact integer arithmetic over a nine-stage pipeline.
// ----------------------------------------------------------------------------
//
//   Channel  Ports              Direction  Carries
//   -------  -----------------  ---------  ---------------------------------
//   query    req_if (sink)      in         centre and three vertices, Q16.16
//   answer   rsp_if (source)    out        hit bit
//   radius   csr_write_*        in         sphere radius, unsigned Q11.16
//
// One query is taken per cycle while the pipeline advances. The pipeline depth
// is set by the two chained wide multiplier stages (Gram terms, then squared
// plane offset), each registering its partial products and then their sum.
// Reset is synchronous and clears the valid bits and the radius to 5.0.
// The whole pipeline holds as one when an answer waits and rsp_if.ready is
// low; nothing is lost or repeated across a stall.
// ----------------------------------------------------------------------------
module sphere_triangle_overlap_test #(
   parameter int COORD_FRAC_BITS = stto_pkg::COORD_FRAC_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [stto_pkg::RADIUS_W-1:0]        csr_write_data,
   stto_req_if.sink                             req_if,
   stto_rsp_if.source                           rsp_if
);
   import stto_pkg::*;

   // A triangle is degenerate when its Gram determinant times 1e8 falls
   // below 2^(4*frac). That equals a compare against a rounded-up quotient.
   localparam logic [AREA_W-1:0] DEGEN_LIMIT =
      ((AREA_W'(1) << (4 * COORD_FRAC_BITS)) + AREA_W'(DEGEN_SCALE) - AREA_W'(1))
      / AREA_W'(DEGEN_SCALE);

   localparam int OFF_W  = DIFF_W + NRM_W + 2;   // plane offset times normal length
   localparam int RSQS_W = RSQ_W + 1;            // squared radius as a signed value
   localparam int EM_W   = 2 * DOT_W + 1;        // mid-edge distance residual
   localparam int RS_W   = DOT_W + RSQS_W;       // squared radius times edge length

   // ------------------------------------------------------------------------
   // Handshake and valid bits. The pipeline moves when the output register
   // is empty or being taken.
   // ------------------------------------------------------------------------
   logic       advance;
   logic       accept;
   logic [9:1] valid_ff;
   logic [9:1] valid_in;

   assign advance      = !valid_ff[9] || rsp_if.ready;
   assign req_if.ready = advance;
   assign accept       = req_if.valid && advance;
   assign valid_in     = {valid_ff[8:1], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   // ------------------------------------------------------------------------
   // Radius register and its square. The user must change the radius only while the
   // pipeline is empty (unchecked by the block), so the square is stable in flight.
   // ------------------------------------------------------------------------
   logic [RADIUS_W-1:0]      radius_ff;
   logic [RSQ_W-1:0]         rsq_ff;
   logic signed [RSQS_W-1:0] rsq_s;
   logic signed [DOT_W-1:0]  rsq_dot;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RADIUS_RESET;
      end else if (csr_write_enable) begin
         radius_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      rsq_ff <= RSQ_W'(radius_ff) * RSQ_W'(radius_ff);
   end

   assign rsq_s   = $signed({1'b0, rsq_ff});
   assign rsq_dot = DOT_W'(rsq_s);

   // ------------------------------------------------------------------------
   // Stages 1 to 3: differences, products, dot and cross products.
   // ------------------------------------------------------------------------
   logic signed [COORD_W-1:0] cen [3];
   logic signed [COORD_W-1:0] va  [3];
   logic signed [COORD_W-1:0] vb  [3];
   logic signed [COORD_W-1:0] vc  [3];
   stto_geom_type             geom;

   assign cen[0] = req_if.center_x;
   assign cen[1] = req_if.center_y;
   assign cen[2] = req_if.center_z;
   assign va[0]  = req_if.vertex_a_x;
   assign va[1]  = req_if.vertex_a_y;
   assign va[2]  = req_if.vertex_a_z;
   assign vb[0]  = req_if.vertex_b_x;
   assign vb[1]  = req_if.vertex_b_y;
   assign vb[2]  = req_if.vertex_b_z;
   assign vc[0]  = req_if.vertex_c_x;
   assign vc[1]  = req_if.vertex_c_y;
   assign vc[2]  = req_if.vertex_c_z;

   stto_geom u_geom (
      .clock   (clock),
      .advance (advance),
      .cen     (cen),
      .va      (va),
      .vb      (vb),
      .vc      (vc),
      .geom    (geom)
   );

   // ------------------------------------------------------------------------
   // Per-edge terms. Edge 0 runs a to b, edge 1 b to c, edge 2 c to a. Each
   // edge sees the squared distance from the centre to its start (rel2),
   // its squared length (len2) and the projection along it (along).
   // ------------------------------------------------------------------------
   logic signed [DOT_W-1:0] e_rel2  [3];
   logic signed [DOT_W-1:0] e_len2  [3];
   logic signed [DOT_W-1:0] e_along [3];
   logic                    near_a, near_b, near_c;
   stto_flags_type          flags_in;
   stto_flags_type          flags_t4_ff, flags_t5_ff, flags_t6_ff;

   always_comb begin
      e_rel2[0]  = geom.rr_a;
      e_len2[0]  = geom.bb;
      e_along[0] = geom.pb;
      e_rel2[1]  = geom.rr_b;
      e_len2[1]  = geom.len_bc;
      e_along[1] = geom.al_bc;
      e_rel2[2]  = geom.rr_c;
      e_len2[2]  = geom.cc;
      e_along[2] = geom.al_ca;
   end

   // Stage 4 flags: vertex distances against the radius and where the
   // centre projects along each edge.
   always_comb begin
      near_a = geom.rr_a <= rsq_dot;
      near_b = geom.rr_b <= rsq_dot;
      near_c = geom.rr_c <= rsq_dot;
      flags_in.start_near = {near_c, near_b, near_a};
      flags_in.end_near   = {near_a, near_c, near_b};
      flags_in.vtx_a_near = near_a;
      for (int k = 0; k < 3; k++) begin
         flags_in.start_behind[k] = e_along[k] <= DOT_W'(0);
         flags_in.end_beyond[k]   = e_along[k] >= e_len2[k];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         flags_t4_ff <= flags_in;
         flags_t5_ff <= flags_t4_ff;
         flags_t6_ff <= flags_t5_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Stages 4 and 5: wide products of the dot terms, the squared radius and the normal.
   // ------------------------------------------------------------------------
   logic signed [2*DOT_W-1:0]       m_bbcc, m_bcbc, m_ccpb, m_bcpc, m_bbpc, m_bcpb;
   logic signed [NRM_W+DIFF_W-1:0]  m_off [3];
   logic signed [2*DOT_W-1:0]       m_rl  [3];
   logic signed [2*DOT_W-1:0]       m_aa  [3];
   logic signed [RS_W-1:0]          m_rs  [3];

   stto_mul #(.AW(DOT_W), .BW(DOT_W)) u_mul_bbcc (
      .clock(clock), .advance(advance), .a(geom.bb), .b(geom.cc), .p(m_bbcc));
   stto_mul #(.AW(DOT_W), .BW(DOT_W)) u_mul_bcbc (
      .clock(clock), .advance(advance), .a(geom.bc), .b(geom.bc), .p(m_bcbc));
   stto_mul #(.AW(DOT_W), .BW(DOT_W)) u_mul_ccpb (
      .clock(clock), .advance(advance), .a(geom.cc), .b(geom.pb), .p(m_ccpb));
   stto_mul #(.AW(DOT_W), .BW(DOT_W)) u_mul_bcpc (
      .clock(clock), .advance(advance), .a(geom.bc), .b(geom.pc), .p(m_bcpc));
   stto_mul #(.AW(DOT_W), .BW(DOT_W)) u_mul_bbpc (
      .clock(clock), .advance(advance), .a(geom.bb), .b(geom.pc), .p(m_bbpc));
   stto_mul #(.AW(DOT_W), .BW(DOT_W)) u_mul_bcpb (
      .clock(clock), .advance(advance), .a(geom.bc), .b(geom.pb), .p(m_bcpb));

   for (genvar k = 0; k < 3; k++) begin : g_wide
      stto_mul #(.AW(NRM_W), .BW(DIFF_W)) u_mul_off (
         .clock   (clock),
         .advance (advance),
         .a       ($signed(geom.nrm[k])),
         .b       ($signed(geom.rp[k])),
         .p       (m_off[k])
      );
      stto_mul #(.AW(DOT_W), .BW(DOT_W)) u_mul_rl (
         .clock(clock), .advance(advance), .a(e_rel2[k]), .b(e_len2[k]), .p(m_rl[k]));
      stto_mul #(.AW(DOT_W), .BW(DOT_W)) u_mul_aa (
         .clock(clock), .advance(advance), .a(e_along[k]), .b(e_along[k]), .p(m_aa[k]));
      stto_mul #(.AW(DOT_W), .BW(RSQS_W)) u_mul_rs (
         .clock(clock), .advance(advance), .a(e_len2[k]), .b(rsq_s), .p(m_rs[k]));
   end

   // ------------------------------------------------------------------------
   // Stage 6: Gram determinant, plane offset, barycentric numerators and
   // the mid-edge residuals rel2*len2 - along^2.
   // ------------------------------------------------------------------------
   logic signed [AREA_W-1:0] area2_ff, nb_ff, nc_ff;
   logic signed [OFF_W-1:0]  off_ff;
   logic signed [EM_W-1:0]   em_ff [3];
   logic signed [RS_W-1:0]   rs_ff [3];

   always_ff @(posedge clock) begin
      if (advance) begin
         area2_ff <= AREA_W'(m_bbcc) - AREA_W'(m_bcbc);
         nb_ff    <= AREA_W'(m_ccpb) - AREA_W'(m_bcpc);
         nc_ff    <= AREA_W'(m_bbpc) - AREA_W'(m_bcpb);
         off_ff   <= OFF_W'(m_off[0]) + OFF_W'(m_off[1]) + OFF_W'(m_off[2]);
         for (int k = 0; k < 3; k++) begin
            em_ff[k] <= EM_W'(m_rl[k]) - EM_W'(m_aa[k]);
            rs_ff[k] <= m_rs[k];
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stages 7 and 8: squared plane offset against the radius bound, while
   // the inside test, the edge tests and the degenerate check settle.
   // ------------------------------------------------------------------------
   logic signed [2*OFF_W-1:0]       m_off2;
   logic signed [AREA_W+RSQS_W-1:0] m_rsqa;

   stto_mul #(.AW(OFF_W), .BW(OFF_W)) u_mul_off2 (
      .clock(clock), .advance(advance), .a(off_ff), .b(off_ff), .p(m_off2));
   stto_mul #(.AW(AREA_W), .BW(RSQS_W)) u_mul_rsqa (
      .clock(clock), .advance(advance), .a(area2_ff), .b(rsq_s), .p(m_rsqa));

   logic signed [AREA_W+1:0] na;
   logic [2:0]               edge_hit;
   logic                     degen_ff, cand_ff, near_a_t7_ff;
   logic                     degen_t8_ff, cand_t8_ff, near_a_t8_ff;

   // The centre projects inside when all three barycentric numerators are
   // nonnegative. An edge is hit at its start or end when the projection
   // falls off that end, and by the perpendicular distance otherwise.
   always_comb begin
      na = (AREA_W + 2)'(area2_ff) - (AREA_W + 2)'(nb_ff) - (AREA_W + 2)'(nc_ff);
      for (int k = 0; k < 3; k++) begin
         if (flags_t6_ff.start_behind[k]) begin
            edge_hit[k] = flags_t6_ff.start_near[k];
         end else if (flags_t6_ff.end_beyond[k]) begin
            edge_hit[k] = flags_t6_ff.end_near[k];
         end else begin
            edge_hit[k] = em_ff[k] <= EM_W'(rs_ff[k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         degen_ff     <= $unsigned(area2_ff) < DEGEN_LIMIT;
         cand_ff      <= (!nb_ff[AREA_W-1] && !nc_ff[AREA_W-1] && !na[AREA_W+1])
                         || (|edge_hit);
         near_a_t7_ff <= flags_t6_ff.vtx_a_near;
         degen_t8_ff  <= degen_ff;
         cand_t8_ff   <= cand_ff;
         near_a_t8_ff <= near_a_t7_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 9: answer register. A degenerate triangle falls back to the
   // distance to vertex a and skips the plane test.
   // ------------------------------------------------------------------------
   logic plane_ok;
   logic hit_ff;

   assign plane_ok = m_off2 <= (2*OFF_W)'(m_rsqa);

   always_ff @(posedge clock) begin
      if (advance) begin
         hit_ff <= degen_t8_ff ? near_a_t8_ff : (plane_ok && cand_t8_ff);
      end
   end

   assign rsp_if.valid = valid_ff[9];
   assign rsp_if.hit   = hit_ff;

   // ------------------------------------------------------------------------
   // Checks on the arithmetic: the Gram determinant, the mid-edge residuals and
   // the squared edge lengths are never negative, the first two by Cauchy-Schwarz.
   // ------------------------------------------------------------------------
   assert property (@(posedge clock) disable iff (reset)
      valid_ff[6] |-> !area2_ff[AREA_W-1])
      else $error("Gram determinant came out negative");

   assert property (@(posedge clock) disable iff (reset)
      valid_ff[6] |-> !em_ff[0][EM_W-1] && !em_ff[1][EM_W-1] && !em_ff[2][EM_W-1])
      else $error("Mid-edge residual came out negative");

   assert property (@(posedge clock) disable iff (reset)
      valid_ff[3] |-> !geom.bb[DOT_W-1] && !geom.cc[DOT_W-1] && !geom.len_bc[DOT_W-1])
      else $error("Squared edge length came out negative");

endmodule

// ----- verif/sphere_triangle_overlap_test_test.sv -----
// ----------------------------------------------------------------------------
// Sphere/triangle overlap test bench
// Drives centre/triangle queries through the overlap pipeline with random
// gaps and stalls, predicts every hit bit with exact wide integer arithmetic
// and compares the answers in order, over several radius settings.
// ----------------------------------------------------------------------------
module sphere_triangle_overlap_test_test;
   timeunit 1ns;
   timeprecision 1ps;
   import stto_pkg::*;

   typedef logic signed [255:0] wide_type;

   // One query: index 0 is the centre, 1..3 are vertices a, b and c.
   typedef struct {
      logic signed [COORD_W-1:0] pt[4][3];
   } query_type;

   // Real-unit threshold 1e-8 on the Gram determinant, in raw units scaled by 1e8.
   localparam wide_type DEGEN_LIMIT = wide_type'(1) << (4 * COORD_FRAC_BITS_DEFAULT);
   localparam longint ONE = 65536;

   // Holds the pending hit bits and the radius that the block currently uses.
   class hit_scoreboard;
      logic [RADIUS_W-1:0] radius;
      bit                  hits_due[$];
      int                  mismatches;

      function new();
         radius     = RADIUS_RESET;
         mismatches = 0;
      endfunction

      static function wide_type dot(input wide_type x[3], input wide_type y[3]);
         return x[0] * y[0] + x[1] * y[1] + x[2] * y[2];
      endfunction

      // True when the centre lies within the radius of the segment p0..p1.
      static function bit near_segment(input wide_type cen[3], input wide_type p0[3],
                                       input wide_type p1[3], input wide_type rsq);
         wide_type dir[3], rel[3], rel1[3];
         wide_type len2, along, rel2;
         for (int k = 0; k < 3; k++) begin
            dir[k]  = p1[k] - p0[k];
            rel[k]  = cen[k] - p0[k];
            rel1[k] = cen[k] - p1[k];
         end
         len2  = dot(dir, dir);
         along = dot(rel, dir);
         rel2  = dot(rel, rel);
         if (along <= 0) return rel2 <= rsq;
         if (along >= len2) return dot(rel1, rel1) <= rsq;
         return rel2 * len2 - along * along <= rsq * len2;
      endfunction

      function bit predict_hit(input query_type q);
         wide_type cen[3], va[3], vb[3], vc[3], eb[3], ec[3], rp[3], nrm[3];
         wide_type rad, rsq, bb, bc, cc, area2, off, pb, pc, nb, nc, na;
         for (int k = 0; k < 3; k++) begin
            cen[k] = wide_type'(q.pt[0][k]);
            va[k]  = wide_type'(q.pt[1][k]);
            vb[k]  = wide_type'(q.pt[2][k]);
            vc[k]  = wide_type'(q.pt[3][k]);
            eb[k]  = vb[k] - va[k];
            ec[k]  = vc[k] - va[k];
            rp[k]  = cen[k] - va[k];
         end
         rad = '0;
         rad[RADIUS_W-1:0] = radius;
         rsq   = rad * rad;
         bb    = dot(eb, eb);
         bc    = dot(eb, ec);
         cc    = dot(ec, ec);
         area2 = bb * cc - bc * bc;
         // A (nearly) flat triangle collapses onto vertex a.
         if (area2 * 100000000 < DEGEN_LIMIT) return dot(rp, rp) <= rsq;
         nrm[0] = eb[1] * ec[2] - eb[2] * ec[1];
         nrm[1] = eb[2] * ec[0] - eb[0] * ec[2];
         nrm[2] = eb[0] * ec[1] - eb[1] * ec[0];
         off = dot(rp, nrm);
         if (off * off > rsq * area2) return 1'b0;
         pb = dot(rp, eb);
         pc = dot(rp, ec);
         nb = cc * pb - bc * pc;
         nc = bb * pc - bc * pb;
         na = area2 - nb - nc;
         if (nb >= 0 && nc >= 0 && na >= 0) return 1'b1;
         return near_segment(cen, va, vb, rsq) || near_segment(cen, vb, vc, rsq)
             || near_segment(cen, vc, va, rsq);
      endfunction

      function void note_query(input query_type q);
         hits_due = {hits_due, predict_hit(q)};
      endfunction

      function void check_answer(input logic hit);
         bit want;
         if (hits_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected answer hit=%b", hit);
            return;
         end
         want = hits_due.pop_front();
         if (hit !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("hit mismatch: expected %b, got %b", want, hit);
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic [RADIUS_W-1:0] csr_write_data;

   stto_req_if req_bus ();
   stto_rsp_if rsp_bus ();

   sphere_triangle_overlap_test dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_if           (req_bus),
      .rsp_if           (rsp_bus)
   );

   hit_scoreboard board = new();
   query_type     queries[$];
   bit            hold_answers;   // asks the receiver for one long hold-off

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // Puts a query on the channel payload.
   task automatic drive_payload(input query_type q);
      req_bus.center_x   <= q.pt[0][0];
      req_bus.center_y   <= q.pt[0][1];
      req_bus.center_z   <= q.pt[0][2];
      req_bus.vertex_a_x <= q.pt[1][0];
      req_bus.vertex_a_y <= q.pt[1][1];
      req_bus.vertex_a_z <= q.pt[1][2];
      req_bus.vertex_b_x <= q.pt[2][0];
      req_bus.vertex_b_y <= q.pt[2][1];
      req_bus.vertex_b_z <= q.pt[2][2];
      req_bus.vertex_c_x <= q.pt[3][0];
      req_bus.vertex_c_y <= q.pt[3][1];
      req_bus.vertex_c_z <= q.pt[3][2];
   endtask

   // Sends every queued query. Valid stays high across back-to-back
   // transfers, so it is only lowered when a gap is actually drawn.
   task automatic send_queries();
      int gap;
      while (queries.size() > 0) begin
         gap = $urandom_range(0, 3);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         drive_payload(queries[0]);
         req_bus.valid <= 1'b1;
         do @(posedge clock); while (!req_bus.ready);
         board.note_query(queries.pop_front());
      end
      req_bus.valid <= 1'b0;
   endtask

   // The radius may only change once the pipeline has drained; the extra
   // cycles cover the nine-stage depth.
   task automatic write_radius(input logic [RADIUS_W-1:0] value);
      while (board.hits_due.size() > 0) @(posedge clock);
      repeat (12) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      board.radius = value;
   endtask

   // Builds a query from twelve coordinates in whole units.
   function automatic query_type in_units(input int v[12]);
      query_type q;
      for (int i = 0; i < 12; i++) q.pt[i / 3][i % 3] = COORD_W'(longint'(v[i]) * ONE);
      return q;
   endfunction

   function automatic query_type all_coords(input logic signed [COORD_W-1:0] cen,
                                            input logic signed [COORD_W-1:0] vtx);
      query_type q;
      for (int k = 0; k < 3; k++) begin
         q.pt[0][k] = cen;
         for (int j = 1; j < 4; j++) q.pt[j][k] = vtx;
      end
      return q;
   endfunction

   // Random query: mostly a triangle and centre clustered around one point,
   // so that plane rejects, inside hits and edge tests all occur; the rest
   // is noise over the full 32-bit range.
   function automatic query_type random_query();
      query_type q;
      longint base, span;
      if ($urandom_range(0, 4) == 0) begin
         for (int i = 0; i < 12; i++) q.pt[i / 3][i % 3] = $urandom;
         return q;
      end
      span = longint'(1) << $urandom_range(2, 22);
      for (int k = 0; k < 3; k++) begin
         base = longint'($urandom_range(0, 1 << 29)) - (1 << 28);
         for (int j = 0; j < 4; j++)
            q.pt[j][k] = COORD_W'(base + longint'($urandom_range(0, 2 * span)) - span);
      end
      // Now and then flatten the triangle and the centre into the plane z of vertex a.
      if ($urandom_range(0, 5) == 0) begin
         q.pt[2][2] = q.pt[1][2];
         q.pt[3][2] = q.pt[1][2];
         q.pt[0][2] = q.pt[1][2];
      end
      return q;
   endfunction

   task automatic random_phase(input int count);
      repeat (count) queries = {queries, random_query()};
      send_queries();
   endtask

   // Receiver: a random stall, possibly none, before each answer, and one long
   // hold-off on request so the pipeline fills and stalls its input.
   initial begin
      int stall;
      rsp_bus.ready <= 1'b0;
      @(negedge reset);
      forever begin
         stall = hold_answers ? 60 : $urandom_range(0, 3);
         hold_answers = 1'b0;
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         board.check_answer(rsp_bus.hit);
      end
   end

   // Main sequence.
   initial begin
      query_type q;
      reset            <= 1'b1;
      csr_write_enable <= 1'b0;
      csr_write_data   <= '0;
      req_bus.valid    <= 1'b0;
      hold_answers     = 1'b0;
      drive_payload(all_coords('0, '0));
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed queries at the reset radius of 5.0, against a right
      // triangle in the z = 0 plane with legs of ten units.
      queries = {queries, in_units('{2, 2, 3,    0, 0, 0,  10, 0, 0,  0, 10, 0})};
      queries = {queries, in_units('{2, 2, 6,    0, 0, 0,  10, 0, 0,  0, 10, 0})};
      // Centre exactly one radius above the face: touching counts.
      queries = {queries, in_units('{2, 2, 5,    0, 0, 0,  10, 0, 0,  0, 10, 0})};
      queries = {queries, in_units('{-3, 2, 0,   0, 0, 0,  10, 0, 0,  0, 10, 0})};
      queries = {queries, in_units('{15, 15, 0,  0, 0, 0,  10, 0, 0,  0, 10, 0})};
      // Past the end of edge ab, exactly one radius from vertex b.
      queries = {queries, in_units('{13, 0, 4,   0, 0, 0,  10, 0, 0,  0, 10, 0})};
      queries = {queries, in_units('{13, 0, 5,   0, 0, 0,  10, 0, 0,  0, 10, 0})};
      // Collapsed triangles fall back to the distance from vertex a.
      queries = {queries, in_units('{3, 4, 0,    0, 0, 0,  0, 0, 0,   0, 0, 0})};
      queries = {queries, in_units('{3, 4, 1,    0, 0, 0,  0, 0, 0,   0, 0, 0})};
      queries = {queries, in_units('{0, 0, 4,    0, 0, 0,  1, 0, 0,   2, 0, 0})};
      queries = {queries, in_units('{9, 0, 0,    0, 0, 0,  1, 0, 0,   2, 0, 0})};
      // A raw-unit triangle is far below the area threshold.
      q = all_coords(32'sd3, 32'sd0);
      q.pt[2][0] = 32'sd1;
      q.pt[3][1] = 32'sd1;
      queries = {queries, q};
      // Field extremes.
      queries = {queries, all_coords(32'sh7fffffff, 32'sh7fffffff)};
      queries = {queries, all_coords(32'sh80000000, 32'sh80000000)};
      queries = {queries, all_coords(32'sh80000000, 32'sh7fffffff)};
      q = all_coords(32'sh80000000, 32'sh80000000);
      q.pt[0][0] = '0;
      q.pt[0][1] = '0;
      q.pt[2][0] = 32'sh7fffffff;
      q.pt[3][1] = 32'sh7fffffff;
      queries = {queries, q};
      q.pt[0][2] = 32'sh80000000 + 32'sd65536;
      queries = {queries, q};
      send_queries();
      random_phase(120);

      // Zero radius: only exact contact hits.
      write_radius('0);
      queries = {queries, in_units('{2, 2, 0,    0, 0, 0,  10, 0, 0,  0, 10, 0})};
      queries = {queries, in_units('{10, 0, 0,   0, 0, 0,  10, 0, 0,  0, 10, 0})};
      send_queries();
      random_phase(100);

      // Largest radius, with the long receiver hold-off in this phase.
      write_radius({RADIUS_W{1'b1}});
      queries = {queries, all_coords(32'sh80000000, 32'sh7fffffff)};
      hold_answers = 1'b1;
      random_phase(130);

      write_radius(27'd1);
      random_phase(100);

      write_radius(RADIUS_W'($urandom_range(1 << 12, 1 << 22)));
      random_phase(120);

      // Drain, then let the pipeline settle.
      fork
         while (board.hits_due.size() > 0) @(posedge clock);
      join
      repeat (20) @(posedge clock);
      if (board.mismatches == 0 && board.hits_due.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // Timeout well above the slowest correct run.
   initial begin
      #5ms;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

// ----- files.f -----
src/stto_pkg.sv
src/stto_req_if.sv
src/stto_rsp_if.sv
src/stto_mul.sv
src/stto_geom.sv
src/sphere_triangle_overlap_test.sv
verif/sphere_triangle_overlap_test_test.sv
